// ----- rtl/frl_pkg.sv -----
// Shared types and constants for the fixed window I/O rate limiter.
package frl_pkg;

    localparam int MAX_DELAY_MS_DEF     = 30000;
    localparam int BYTE_TALLY_WIDTH_DEF = 48;

    localparam int REQ_W        = 32;
    localparam int BLIM_W       = 48;
    localparam int FIX_W        = 32;
    localparam int BC_W         = 24;
    localparam int SEC_W        = 32;
    localparam int DELAY_W      = 15;
    localparam int MS_PER_SECOND = 1000;
    localparam int MS_W         = $clog2(MS_PER_SECOND + 1);

    localparam int QUEUE_DEPTH  = 2;
    localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW     = $clog2(QUEUE_DEPTH + 1);

    localparam int APB_DATA_W   = 64;
    localparam int APB_ADDR_W   = 6;
    localparam int REG_IDX_LSB  = 3;
    localparam int REG_IDX_W    = APB_ADDR_W - REG_IDX_LSB;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_RD_REQ_LIMIT   = 3'd0,
        REG_RD_BYTE_LIMIT  = 3'd1,
        REG_RD_FIXED_DELAY = 3'd2,
        REG_WR_REQ_LIMIT   = 3'd3,
        REG_WR_BYTE_LIMIT  = 3'd4,
        REG_WR_FIXED_DELAY = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [REQ_W-1:0]  req_limit;
        logic [BLIM_W-1:0] byte_limit;
        logic [FIX_W-1:0]  fixed_delay;
    } t_limit_cfg;

    typedef enum logic {
        JOB_DIRECT = 1'b0,
        JOB_DIVIDE = 1'b1
    } t_job_kind;

    typedef enum logic [1:0] {
        BK_IDLE  = 2'd0,
        BK_CHECK = 2'd1,
        BK_DIV   = 2'd2,
        BK_SCALE = 2'd3
    } t_back_state;

endpackage

// ----- rtl/frl_front.sv -----
// Front end: window tallies per direction and classification into delay jobs.
module frl_front #(
    parameter int MAX_DELAY_MS     = frl_pkg::MAX_DELAY_MS_DEF,
    parameter int BYTE_TALLY_WIDTH = frl_pkg::BYTE_TALLY_WIDTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  frl_pkg::t_limit_cfg [1:0]             i_cfg,
    input  logic                                  i_push,
    output logic                                  o_full,
    input  logic                                  i_cmd,
    input  logic [frl_pkg::BC_W-1:0]              i_byte_count,
    input  logic [frl_pkg::SEC_W-1:0]             i_now_seconds,
    output logic                                  o_job_valid,
    input  logic                                  i_job_full,
    output frl_pkg::t_job_kind                    o_job_kind,
    output logic [$clog2(MAX_DELAY_MS+1)-1:0]     o_job_direct,
    output logic [((BYTE_TALLY_WIDTH > frl_pkg::BLIM_W) ?
                   BYTE_TALLY_WIDTH : frl_pkg::BLIM_W)-1:0] o_job_dividend,
    output logic [((BYTE_TALLY_WIDTH > frl_pkg::BLIM_W) ?
                   BYTE_TALLY_WIDTH : frl_pkg::BLIM_W)-1:0] o_job_divisor
);
    localparam int BTW   = BYTE_TALLY_WIDTH;
    localparam int CW    = (BTW > frl_pkg::BLIM_W) ? BTW : frl_pkg::BLIM_W;
    localparam int CAP_W = $clog2(MAX_DELAY_MS + 1);
    localparam int RW    = frl_pkg::REQ_W;

    logic [frl_pkg::SEC_W-1:0] r_win_sec [2];
    logic [RW-1:0]             r_req_tally [2];
    logic [BTW-1:0]            r_byte_tally [2];
    logic                      r_dir;
    logic                      r_pend;

    logic                      accept;
    logic                      same_win;
    logic [RW-1:0]             n_req;
    logic [BTW:0]              byte_sum;
    logic [BTW-1:0]            n_byte;

    assign accept   = i_push && !r_pend;
    assign o_full   = r_pend;
    assign same_win = (r_win_sec[i_cmd] == i_now_seconds);
    assign byte_sum = {1'b0, r_byte_tally[i_cmd]} + (BTW+1)'(i_byte_count);

    always_comb begin
        if (!same_win) begin
            n_req  = RW'(1);
            n_byte = BTW'(i_byte_count);
        end else begin
            n_req  = (&r_req_tally[i_cmd]) ? r_req_tally[i_cmd] : r_req_tally[i_cmd] + RW'(1);
            n_byte = byte_sum[BTW] ? {BTW{1'b1}} : byte_sum[BTW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            r_dir  <= 1'b0;
            for (int d = 0; d < 2; d++) begin
                r_win_sec[d]    <= '0;
                r_req_tally[d]  <= '0;
                r_byte_tally[d] <= '0;
            end
        end else begin
            if (accept) begin
                r_pend                <= 1'b1;
                r_dir                 <= i_cmd;
                r_win_sec[i_cmd]      <= i_now_seconds;
                r_req_tally[i_cmd]    <= n_req;
                r_byte_tally[i_cmd]   <= n_byte;
            end else if (r_pend && !i_job_full) begin
                r_pend <= 1'b0;
            end
        end
    end

    // Classification of the updated window; byte limit takes priority.
    frl_pkg::t_limit_cfg cfg;
    logic [CW-1:0]       byte_cw;
    logic [CW-1:0]       blim_cw;
    logic                byte_hit;
    logic                req_hit;
    logic                has_fixed;
    logic [CAP_W-1:0]    fixed_capped;

    assign cfg       = i_cfg[r_dir];
    assign byte_cw   = CW'(r_byte_tally[r_dir]);
    assign blim_cw   = CW'(cfg.byte_limit);
    assign byte_hit  = (cfg.byte_limit != '0) && (byte_cw > blim_cw);
    assign req_hit   = (cfg.req_limit != '0) && (r_req_tally[r_dir] > cfg.req_limit);
    assign has_fixed = (cfg.fixed_delay != '0);
    assign fixed_capped = (cfg.fixed_delay > frl_pkg::FIX_W'(MAX_DELAY_MS)) ?
                          CAP_W'(MAX_DELAY_MS) : cfg.fixed_delay[CAP_W-1:0];

    assign o_job_valid = r_pend;

    always_comb begin
        o_job_kind     = frl_pkg::JOB_DIRECT;
        o_job_direct   = '0;
        o_job_dividend = byte_cw;
        o_job_divisor  = blim_cw;
        if (byte_hit || req_hit) begin
            if (has_fixed) begin
                o_job_direct = fixed_capped;
            end else begin
                o_job_kind = frl_pkg::JOB_DIVIDE;
                if (!byte_hit) begin
                    o_job_dividend = CW'(r_req_tally[r_dir] - RW'(1));
                    o_job_divisor  = CW'(cfg.req_limit);
                end
            end
        end
    end

endmodule

// ----- rtl/frl_fifo.sv -----
// Short job queue between the front and back ends.
module frl_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int AW = frl_pkg::QUEUE_AW;
    localparam int CN = frl_pkg::QUEUE_CW;

    logic [WIDTH-1:0] r_mem [frl_pkg::QUEUE_DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [CN-1:0]    r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CN'(frl_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(frl_pkg::QUEUE_DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) r_wr_ptr <= ptr_inc(r_wr_ptr);
            if (do_pop)  r_rd_ptr <= ptr_inc(r_rd_ptr);
            if (do_push && !do_pop) begin
                r_count <= r_count + CN'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CN'(1);
            end
        end
    end

endmodule

// ----- rtl/frl_back.sv -----
// Back end: iterative saturating divide, millisecond scaling and result register.
module frl_back #(
    parameter int MAX_DELAY_MS     = frl_pkg::MAX_DELAY_MS_DEF,
    parameter int BYTE_TALLY_WIDTH = frl_pkg::BYTE_TALLY_WIDTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_q_empty,
    output logic                                  o_q_pop,
    input  frl_pkg::t_job_kind                    i_job_kind,
    input  logic [$clog2(MAX_DELAY_MS+1)-1:0]     i_job_direct,
    input  logic [((BYTE_TALLY_WIDTH > frl_pkg::BLIM_W) ?
                   BYTE_TALLY_WIDTH : frl_pkg::BLIM_W)-1:0] i_job_dividend,
    input  logic [((BYTE_TALLY_WIDTH > frl_pkg::BLIM_W) ?
                   BYTE_TALLY_WIDTH : frl_pkg::BLIM_W)-1:0] i_job_divisor,
    output logic                                  o_empty,
    input  logic                                  i_pop,
    output logic [frl_pkg::DELAY_W-1:0]           o_delay_ms
);
    localparam int CW     = (BYTE_TALLY_WIDTH > frl_pkg::BLIM_W) ?
                            BYTE_TALLY_WIDTH : frl_pkg::BLIM_W;
    localparam int CAP_W  = $clog2(MAX_DELAY_MS + 1);
    // quotient saturates one past the largest value that stays under the cap
    localparam int QW     = $clog2(MAX_DELAY_MS / frl_pkg::MS_PER_SECOND + 2);
    localparam int SCW    = $clog2(QW);
    localparam int DW     = CW + QW;
    localparam int PROD_W = QW + frl_pkg::MS_W;

    frl_pkg::t_back_state r_state;
    frl_pkg::t_back_state n_state;

    logic [CW-1:0]    r_rem;
    logic [DW-1:0]    r_dsh;
    logic [QW-1:0]    r_q;
    logic [SCW-1:0]   r_step;
    logic             r_is_div;
    logic [CAP_W-1:0] r_direct;
    logic             r_out_valid;
    logic [CAP_W-1:0] r_out_delay;

    logic             out_free;
    logic             ge;
    logic [PROD_W-1:0] prod;
    logic [CAP_W-1:0] scaled;
    logic [CAP_W-1:0] result;

    logic             load;
    logic             check_en;
    logic             div_en;
    logic             out_wr;

    assign out_free = !r_out_valid || i_pop;
    assign ge       = (DW'(r_rem) >= r_dsh);
    assign prod     = PROD_W'(r_q) * PROD_W'(frl_pkg::MS_PER_SECOND);
    assign scaled   = (prod > PROD_W'(MAX_DELAY_MS)) ? CAP_W'(MAX_DELAY_MS) : prod[CAP_W-1:0];
    assign result   = r_is_div ? scaled : r_direct;

    always_comb begin
        n_state = r_state;
        case (r_state)
            frl_pkg::BK_IDLE: begin
                if (!i_q_empty) begin
                    n_state = (i_job_kind == frl_pkg::JOB_DIVIDE) ?
                              frl_pkg::BK_CHECK : frl_pkg::BK_SCALE;
                end
            end
            frl_pkg::BK_CHECK: begin
                n_state = ge ? frl_pkg::BK_SCALE : frl_pkg::BK_DIV;
            end
            frl_pkg::BK_DIV: begin
                if (r_step == '0) n_state = frl_pkg::BK_SCALE;
            end
            frl_pkg::BK_SCALE: begin
                if (out_free) n_state = frl_pkg::BK_IDLE;
            end
            default: n_state = frl_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        load     = 1'b0;
        check_en = 1'b0;
        div_en   = 1'b0;
        out_wr   = 1'b0;
        case (r_state)
            frl_pkg::BK_IDLE:  load     = !i_q_empty;
            frl_pkg::BK_CHECK: check_en = 1'b1;
            frl_pkg::BK_DIV:   div_en   = 1'b1;
            frl_pkg::BK_SCALE: out_wr   = out_free;
            default: ;
        endcase
    end

    assign o_q_pop = load;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_is_div <= (i_job_kind == frl_pkg::JOB_DIVIDE);
            r_direct <= i_job_direct;
            r_rem    <= i_job_dividend;
            r_dsh    <= {i_job_divisor, {QW{1'b0}}};
            r_q      <= '0;
        end
        if (check_en) begin
            // quotient beyond range: saturate, scaling clamps it to the cap
            if (ge) r_q <= '1;
            r_dsh  <= r_dsh >> 1;
            r_step <= SCW'(QW - 1);
        end
        if (div_en) begin
            if (ge) r_rem <= r_rem - r_dsh[CW-1:0];
            r_q    <= {r_q[QW-2:0], ge};
            r_dsh  <= r_dsh >> 1;
            r_step <= r_step - SCW'(1);
        end
        if (out_wr) begin
            r_out_delay <= result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= frl_pkg::BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_wr) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_empty    = !r_out_valid;
    assign o_delay_ms = frl_pkg::DELAY_W'(r_out_delay);

endmodule

// ----- rtl/fixed_window_io_rate_limiter_unit.sv -----
// Flow: the front end holds an accepted request until the job queue takes it, and takes no
// new request meanwhile (full is high); a 2-entry job queue lets it run ahead of the back end.
// The back end pops one job at a time and goes from IDLE to SCALE for a fixed or zero delay; a
// divide job passes through CHECK (a saturating quotient goes straight on to SCALE) and DIV, one
// quotient bit per DIV step (5 at the default cap). SCALE waits until the result register is free.
// Reset: synchronous, active low; clears limits, window state, queue and result valid flag.
module fixed_window_io_rate_limiter_unit #(
    parameter int MAX_DELAY_MS     = frl_pkg::MAX_DELAY_MS_DEF,
    parameter int BYTE_TALLY_WIDTH = frl_pkg::BYTE_TALLY_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [frl_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [frl_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [frl_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready,
    input  logic                               push,
    output logic                               full,
    input  logic                               i_cmd,
    input  logic [frl_pkg::BC_W-1:0]           i_byte_count,
    input  logic [frl_pkg::SEC_W-1:0]          i_now_seconds,
    output logic                               empty,
    input  logic                               pop,
    output logic [frl_pkg::DELAY_W-1:0]        o_delay_ms
);
    localparam int CW    = (BYTE_TALLY_WIDTH > frl_pkg::BLIM_W) ?
                           BYTE_TALLY_WIDTH : frl_pkg::BLIM_W;
    localparam int CAP_W = $clog2(MAX_DELAY_MS + 1);
    localparam int JW    = 1 + CAP_W + 2 * CW;

    frl_pkg::t_limit_cfg [1:0] r_cfg;
    frl_pkg::t_reg_idx         reg_idx;
    logic                      cfg_wr;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = frl_pkg::t_reg_idx'(paddr[frl_pkg::APB_ADDR_W-1:frl_pkg::REG_IDX_LSB]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (cfg_wr) begin
            case (reg_idx)
                frl_pkg::REG_RD_REQ_LIMIT:   r_cfg[0].req_limit   <= pwdata[frl_pkg::REQ_W-1:0];
                frl_pkg::REG_RD_BYTE_LIMIT:  r_cfg[0].byte_limit  <= pwdata[frl_pkg::BLIM_W-1:0];
                frl_pkg::REG_RD_FIXED_DELAY: r_cfg[0].fixed_delay <= pwdata[frl_pkg::FIX_W-1:0];
                frl_pkg::REG_WR_REQ_LIMIT:   r_cfg[1].req_limit   <= pwdata[frl_pkg::REQ_W-1:0];
                frl_pkg::REG_WR_BYTE_LIMIT:  r_cfg[1].byte_limit  <= pwdata[frl_pkg::BLIM_W-1:0];
                frl_pkg::REG_WR_FIXED_DELAY: r_cfg[1].fixed_delay <= pwdata[frl_pkg::FIX_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            frl_pkg::REG_RD_REQ_LIMIT:   prdata = frl_pkg::APB_DATA_W'(r_cfg[0].req_limit);
            frl_pkg::REG_RD_BYTE_LIMIT:  prdata = frl_pkg::APB_DATA_W'(r_cfg[0].byte_limit);
            frl_pkg::REG_RD_FIXED_DELAY: prdata = frl_pkg::APB_DATA_W'(r_cfg[0].fixed_delay);
            frl_pkg::REG_WR_REQ_LIMIT:   prdata = frl_pkg::APB_DATA_W'(r_cfg[1].req_limit);
            frl_pkg::REG_WR_BYTE_LIMIT:  prdata = frl_pkg::APB_DATA_W'(r_cfg[1].byte_limit);
            frl_pkg::REG_WR_FIXED_DELAY: prdata = frl_pkg::APB_DATA_W'(r_cfg[1].fixed_delay);
            default:                     prdata = '0;
        endcase
    end

    logic                   job_valid;
    logic                   job_full;
    frl_pkg::t_job_kind     job_kind;
    logic [CAP_W-1:0]       job_direct;
    logic [CW-1:0]          job_dividend;
    logic [CW-1:0]          job_divisor;
    logic [JW-1:0]          q_wdata;
    logic [JW-1:0]          q_rdata;
    logic                   q_empty;
    logic                   q_pop;

    frl_front #(
        .MAX_DELAY_MS     (MAX_DELAY_MS),
        .BYTE_TALLY_WIDTH (BYTE_TALLY_WIDTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_push         (push),
        .o_full         (full),
        .i_cmd          (i_cmd),
        .i_byte_count   (i_byte_count),
        .i_now_seconds  (i_now_seconds),
        .o_job_valid    (job_valid),
        .i_job_full     (job_full),
        .o_job_kind     (job_kind),
        .o_job_direct   (job_direct),
        .o_job_dividend (job_dividend),
        .o_job_divisor  (job_divisor)
    );

    assign q_wdata = {job_kind, job_direct, job_dividend, job_divisor};

    frl_fifo #(
        .WIDTH (JW)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_valid),
        .i_data  (q_wdata),
        .o_full  (job_full),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty)
    );

    frl_back #(
        .MAX_DELAY_MS     (MAX_DELAY_MS),
        .BYTE_TALLY_WIDTH (BYTE_TALLY_WIDTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .o_q_pop        (q_pop),
        .i_job_kind     (frl_pkg::t_job_kind'(q_rdata[JW-1])),
        .i_job_direct   (q_rdata[JW-2 -: CAP_W]),
        .i_job_dividend (q_rdata[2*CW-1:CW]),
        .i_job_divisor  (q_rdata[CW-1:0]),
        .o_empty        (empty),
        .i_pop          (pop),
        .o_delay_ms     (o_delay_ms)
    );

endmodule

// ----- tb/tb_fixed_window_io_rate_limiter_unit.sv -----
// Self-checking testbench for the fixed window I/O rate limiter, with directed and random requests.
module tb_fixed_window_io_rate_limiter_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import frl_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int CYCLE_LIMIT    = 400_000;
    localparam int PHASES         = 14;
    localparam int BEATS_PER_PHASE = 75;
    localparam int HOLD_CYCLES    = 150;
    localparam int TAIL_CYCLES    = 20;
    localparam int MAX_IDLE       = 11;

    localparam logic DIR_READ  = 1'b0;
    localparam logic DIR_WRITE = 1'b1;

    // addresses past the register list, writes there must be dropped
    localparam logic [REG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    localparam logic [63:0]        DELAY_CAP = 64'(MAX_DELAY_MS_DEF);
    localparam logic [BLIM_W-1:0]  TALLY_MAX = '1;

    typedef struct packed {
        logic                 is_cfg;
        logic [REG_IDX_W-1:0] reg_idx;
        logic [63:0]          reg_val;
        logic                 cmd;
        logic [BC_W-1:0]      bytes;
        logic [SEC_W-1:0]     sec;
        logic                 typed;
        logic [DELAY_W-1:0]   want;
    } stim_row_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  push = 1'b0;
    logic                  full;
    logic                  i_cmd = 1'b0;
    logic [BC_W-1:0]       i_byte_count = '0;
    logic [SEC_W-1:0]      i_now_seconds = '0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic [DELAY_W-1:0]    o_delay_ms;

    // typed-in expectation that travels with the beat on the input side
    logic                  beat_typed = 1'b0;
    logic [DELAY_W-1:0]    beat_want = '0;

    // limiter shadow state
    logic [REQ_W-1:0]  req_lim [2];
    logic [BLIM_W-1:0] byte_lim [2];
    logic [FIX_W-1:0]  fix_dly [2];
    logic [SEC_W-1:0]  win_sec [2];
    logic [REQ_W-1:0]  req_tally [2];
    logic [BLIM_W-1:0] byte_tally [2];

    logic [DELAY_W-1:0] pending_delays [$];

    int  n_sent = 0;
    int  n_results = 0;
    int  mismatches = 0;
    int  input_stalls = 0;
    int  holds_done = 0;
    int  cycle_count = 0;
    int  max_gap = MAX_IDLE;
    int  max_stall = MAX_IDLE;
    bit  hold_req = 1'b0;

    fixed_window_io_rate_limiter_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .push          (push),
        .full          (full),
        .i_cmd         (i_cmd),
        .i_byte_count  (i_byte_count),
        .i_now_seconds (i_now_seconds),
        .empty         (empty),
        .pop           (pop),
        .o_delay_ms    (o_delay_ms)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic logic [63:0] clamp_delay(input logic [63:0] v);
        return (v > DELAY_CAP) ? DELAY_CAP : v;
    endfunction

    function automatic logic [63:0] scale_delay(input logic [63:0] q);
        if (q > DELAY_CAP)
            return DELAY_CAP;
        return clamp_delay(q * 64'(MS_PER_SECOND));
    endfunction

    // Advances the window of one direction and returns the hold time for the request.
    function automatic logic [DELAY_W-1:0] window_delay(input logic dir,
                                                        input logic [BC_W-1:0] n,
                                                        input logic [SEC_W-1:0] now);
        logic [63:0] d;
        d = 64'd0;
        if (win_sec[dir] != now) begin
            win_sec[dir]    = now;
            req_tally[dir]  = 1;
            byte_tally[dir] = BLIM_W'(n);
        end else begin
            if (req_tally[dir] != '1)
                req_tally[dir] = req_tally[dir] + 1;
            if (byte_tally[dir] > TALLY_MAX - BLIM_W'(n))
                byte_tally[dir] = TALLY_MAX;
            else
                byte_tally[dir] = byte_tally[dir] + BLIM_W'(n);
        end
        // byte limit takes precedence over the request limit
        if (byte_lim[dir] != 0 && byte_tally[dir] > byte_lim[dir]) begin
            if (fix_dly[dir] != 0)
                d = clamp_delay(64'(fix_dly[dir]));
            else
                d = scale_delay(64'(byte_tally[dir] / byte_lim[dir]));
        end else if (req_lim[dir] != 0 && req_tally[dir] > req_lim[dir]) begin
            if (fix_dly[dir] != 0)
                d = clamp_delay(64'(fix_dly[dir]));
            else
                d = scale_delay(64'((req_tally[dir] - 1) / req_lim[dir]));
        end
        return d[DELAY_W-1:0];
    endfunction

    function automatic stim_row_t item_row(input logic cmd, input logic [BC_W-1:0] bytes,
                                           input logic [SEC_W-1:0] sec, input logic typed,
                                           input logic [DELAY_W-1:0] want);
        stim_row_t r;
        r = '0;
        r.cmd   = cmd;
        r.bytes = bytes;
        r.sec   = sec;
        r.typed = typed;
        r.want  = want;
        return r;
    endfunction

    function automatic stim_row_t cfg_row(input logic [REG_IDX_W-1:0] idx, input logic [63:0] val);
        stim_row_t r;
        r = '0;
        r.is_cfg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    task automatic log_mismatch(input string what, input logic [DELAY_W-1:0] want,
                                input logic [DELAY_W-1:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch (%s) at result beat %0d: expected delay_ms=%0d got %0d",
                     what, n_results, want, got);
    endtask

    // Setup then access phase; psel stays up so back-to-back writes go straight from access to the next setup.
    task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [63:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, {REG_IDX_LSB{1'b0}}};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (t_reg_idx'(idx))
            REG_RD_REQ_LIMIT:   req_lim[0]  = val[REQ_W-1:0];
            REG_RD_BYTE_LIMIT:  byte_lim[0] = val[BLIM_W-1:0];
            REG_RD_FIXED_DELAY: fix_dly[0]  = val[FIX_W-1:0];
            REG_WR_REQ_LIMIT:   req_lim[1]  = val[REQ_W-1:0];
            REG_WR_BYTE_LIMIT:  byte_lim[1] = val[BLIM_W-1:0];
            REG_WR_FIXED_DELAY: fix_dly[1]  = val[FIX_W-1:0];
            default: ;
        endcase
    endtask

    task automatic bus_release();
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Sender pause: nothing offered until every delay has come out.
    task automatic wait_all_done();
        push <= 1'b0;
        @(posedge i_clk);
        while (n_results != n_sent)
            @(posedge i_clk);
    endtask

    task automatic send_request(input logic cmd, input logic [BC_W-1:0] bytes,
                                input logic [SEC_W-1:0] sec, input logic typed,
                                input logic [DELAY_W-1:0] want);
        int gap;
        gap = $urandom_range(0, max_gap);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push          <= 1'b1;
        i_cmd         <= cmd;
        i_byte_count  <= bytes;
        i_now_seconds <= sec;
        beat_typed    <= typed;
        beat_want     <= want;
        do @(posedge i_clk); while (full);
        n_sent++;
    endtask

    // Result side monitor and input side predictor, both sampled at the edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pop && !empty) begin
                if (pending_delays.size() == 0)
                    log_mismatch("no request pending", '0, o_delay_ms);
                else if (pending_delays[0] != o_delay_ms)
                    log_mismatch("delay_ms", pending_delays[0], o_delay_ms);
                if (pending_delays.size() != 0)
                    void'(pending_delays.pop_front());
                n_results++;
            end
            if (push && full)
                input_stalls++;
            if (push && !full) begin
                if (beat_typed) begin
                    void'(window_delay(i_cmd, i_byte_count, i_now_seconds));
                    pending_delays.push_back(beat_want);
                end else begin
                    pending_delays.push_back(window_delay(i_cmd, i_byte_count, i_now_seconds));
                end
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off when asked for.
    initial begin
        int stall;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
                holds_done++;
            end
            stall = $urandom_range(0, max_stall);
            if (stall > 0) begin
                pop <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d of %0d delays out", cycle_count, n_results, n_sent);
        $display("FAILURE");
        $finish;
    end

    initial begin
        stim_row_t         plan [$];
        logic [SEC_W-1:0]  sec_cur [2];
        logic [63:0]       v;
        logic [BC_W-1:0]   bytes;
        logic              dir;
        int                roll;

        for (int d = 0; d < 2; d++) begin
            req_lim[d]    = '0;
            byte_lim[d]   = '0;
            fix_dly[d]    = '0;
            win_sec[d]    = '0;
            req_tally[d]  = '0;
            byte_tally[d] = '0;
        end

        // after reset: request in second 0 joins the empty window, all limits off
        plan.push_back(item_row(DIR_READ,  24'd0,        32'd0,        1'b1, 15'd0));
        plan.push_back(item_row(DIR_WRITE, 24'hFF_FFFF,  32'hFFFF_FFFF, 1'b1, 15'd0));
        plan.push_back(cfg_row(REG_RD_REQ_LIMIT,   64'd2));
        plan.push_back(cfg_row(REG_RD_BYTE_LIMIT,  64'd1000));
        plan.push_back(cfg_row(REG_RD_FIXED_DELAY, 64'd0));
        plan.push_back(item_row(DIR_READ,  24'd500,      32'd5, 1'b1, 15'd0));
        plan.push_back(item_row(DIR_READ,  24'd600,      32'd5, 1'b1, 15'd1000));
        plan.push_back(item_row(DIR_READ,  24'd2000,     32'd5, 1'b0, '0));
        plan.push_back(item_row(DIR_READ,  24'd0,        32'd6, 1'b0, '0));
        plan.push_back(item_row(DIR_READ,  24'd0,        32'd6, 1'b0, '0));
        plan.push_back(item_row(DIR_READ,  24'd0,        32'd6, 1'b0, '0));
        // both limits exceeded, byte limit wins and the quotient saturates
        plan.push_back(item_row(DIR_READ,  24'hFF_FFFF,  32'd6, 1'b1, 15'd30000));
        plan.push_back(cfg_row(REG_RD_BYTE_LIMIT,  64'd1));
        plan.push_back(item_row(DIR_READ,  24'd30,       32'd7, 1'b0, '0));
        plan.push_back(item_row(DIR_READ,  24'd29,       32'd8, 1'b0, '0));
        plan.push_back(cfg_row(REG_RD_FIXED_DELAY, 64'hFFFF_FFFF));
        plan.push_back(item_row(DIR_READ,  24'd5,        32'd8, 1'b1, 15'd30000));
        plan.push_back(cfg_row(REG_RD_FIXED_DELAY, 64'd250));
        plan.push_back(item_row(DIR_READ,  24'd5,        32'd8, 1'b1, 15'd250));
        plan.push_back(cfg_row(REG_WR_REQ_LIMIT,   64'd1));
        plan.push_back(cfg_row(REG_WR_BYTE_LIMIT,  64'hFFFF_FFFF_FFFF));
        plan.push_back(cfg_row(REG_WR_FIXED_DELAY, 64'd0));
        plan.push_back(item_row(DIR_WRITE, 24'hFF_FFFF,  32'd3, 1'b0, '0));
        plan.push_back(item_row(DIR_WRITE, 24'd1,        32'd3, 1'b0, '0));
        plan.push_back(cfg_row(REG_WR_FIXED_DELAY, 64'd7));
        plan.push_back(item_row(DIR_WRITE, 24'd0,        32'd3, 1'b0, '0));
        plan.push_back(cfg_row(REG_WR_REQ_LIMIT,   64'hFFFF_FFFF));
        plan.push_back(cfg_row(REG_SPARE_A,        64'hFFFF_FFFF_FFFF_FFFF));
        plan.push_back(cfg_row(REG_SPARE_B,        64'd1));
        plan.push_back(item_row(DIR_WRITE, 24'd0,        32'd3, 1'b0, '0));
        plan.push_back(cfg_row(REG_RD_REQ_LIMIT,   64'd0));
        plan.push_back(cfg_row(REG_RD_BYTE_LIMIT,  64'd0));
        plan.push_back(item_row(DIR_READ,  24'hFF_FFFF,  32'd8, 1'b0, '0));
        plan.push_back(item_row(DIR_READ,  24'd0,        32'd0, 1'b0, '0));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < plan.size(); r++) begin
            if (plan[r].is_cfg) begin
                if (r == 0 || !plan[r-1].is_cfg)
                    wait_all_done();
                reg_write(plan[r].reg_idx, plan[r].reg_val);
                if (r + 1 == plan.size() || !plan[r+1].is_cfg)
                    bus_release();
            end else begin
                send_request(plan[r].cmd, plan[r].bytes, plan[r].sec, plan[r].typed, plan[r].want);
            end
        end

        sec_cur[0] = $urandom;
        sec_cur[1] = $urandom;
        for (int ph = 0; ph < PHASES; ph++) begin
            wait_all_done();
            for (int d = 0; d < 2; d++) begin
                roll = $urandom_range(0, 99);
                if (roll < 20)      v = 64'd0;
                else if (roll < 70) v = 64'($urandom_range(1, 8));
                else if (roll < 85) v = 64'($urandom_range(9, 1000));
                else if (roll < 95) v = 64'($urandom);
                else                v = 64'hFFFF_FFFF;
                if ($urandom_range(0, 1) == 0)
                    v[63:32] = $urandom;    // junk above the register width
                reg_write(d ? REG_WR_REQ_LIMIT : REG_RD_REQ_LIMIT, v);

                roll = $urandom_range(0, 99);
                if (roll < 20)      v = 64'd0;
                else if (roll < 30) v = 64'($urandom_range(1, 100));
                else if (roll < 70) v = 64'($urandom_range(1000, 2_000_000));
                else if (roll < 80) v = 64'($urandom_range(1 << 24, 1 << 26));
                else if (roll < 95) v = {$urandom, $urandom} & 64'hFFFF_FFFF_FFFF;
                else                v = 64'hFFFF_FFFF_FFFF;
                if ($urandom_range(0, 1) == 0)
                    v[63:48] = 16'($urandom);
                reg_write(d ? REG_WR_BYTE_LIMIT : REG_RD_BYTE_LIMIT, v);

                roll = $urandom_range(0, 99);
                if (roll < 60)      v = 64'd0;
                else if (roll < 80) v = 64'($urandom_range(1, 30000));
                else if (roll < 90) v = 64'($urandom_range(30000, 30001));
                else if (roll < 95) v = 64'($urandom);
                else                v = 64'hFFFF_FFFF;
                if ($urandom_range(0, 1) == 0)
                    v[63:32] = $urandom;
                reg_write(d ? REG_WR_FIXED_DELAY : REG_RD_FIXED_DELAY, v);
            end
            if (ph % 3 == 0)
                reg_write(($urandom_range(0, 1) != 0) ? REG_SPARE_A : REG_SPARE_B, {$urandom, $urandom});
            bus_release();

            max_gap   = (ph % 5 == 2) ? 0 : MAX_IDLE;
            max_stall = (ph % 4 == 1) ? 0 : MAX_IDLE;
            if (ph == 3 || ph == 10) begin
                // receiver stops while requests keep coming, so the block backs up
                max_gap  = 0;
                hold_req = 1'b1;
            end

            for (int k = 0; k < BEATS_PER_PHASE; k++) begin
                dir  = 1'($urandom_range(0, 1));
                roll = $urandom_range(0, 99);
                // mostly stay in the current second so the tallies climb past the limits
                if (roll >= 97)      sec_cur[dir] = 32'hFFFF_FFFF;
                else if (roll >= 95) sec_cur[dir] = 32'd0;
                else if (roll >= 90) sec_cur[dir] = $urandom;
                else if (roll >= 75) sec_cur[dir] = sec_cur[dir] + 1;
                roll = $urandom_range(0, 99);
                if (roll < 40)      bytes = 24'($urandom_range(0, 4095));
                else if (roll < 70) bytes = 24'($urandom_range(0, 65535));
                else if (roll < 90) bytes = 24'($urandom);
                else if (roll < 95) bytes = 24'd0;
                else                bytes = 24'hFF_FFFF;
                send_request(dir, bytes, sec_cur[dir], 1'b0, '0);
            end
        end

        wait_all_done();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_delays.size() != 0) begin
            mismatches += pending_delays.size();
            $display("%0d delays never came out", pending_delays.size());
        end

        $display("%0d requests through both windows over %0d limit settings, %0d delays checked",
                 n_sent, PHASES + 1, n_results);
        $display("%0d long receiver hold-offs, input stalled on %0d edges, %0d mismatches",
                 holds_done, input_stalls, mismatches);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/frl_pkg.sv
rtl/frl_front.sv
rtl/frl_fifo.sv
rtl/frl_back.sv
rtl/fixed_window_io_rate_limiter_unit.sv
tb/tb_fixed_window_io_rate_limiter_unit.sv
